// ----- src/bpsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boost pulse drive package
// Shared types and constants for the slewed PWM drive block.
// ----------------------------------------------------------------------------
package bpsd_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MIN_DRIVE   = 2'd0,
    CFG_MAX_DRIVE   = 2'd1,
    CFG_BOOST_DRIVE = 2'd2,
    CFG_SLEW_PER_MS = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] MIN_DRIVE_RST   = 16'd0;
  localparam logic [15:0] MAX_DRIVE_RST   = 16'hFFFF;
  localparam logic [15:0] BOOST_DRIVE_RST = 16'hFFFF;
  localparam logic [15:0] SLEW_RST        = 16'd66;

  // One second of pulse or gap, in milliseconds.
  localparam logic [31:0] PULSE_MS   = 32'd1000;
  // One tenth of full scale in Q0.16.
  localparam logic [15:0] CAP_MARGIN = 16'd6554;
  // Rounding constant for the Q0.16 product.
  localparam logic [32:0] ROUND_HALF = 33'd32768;
  // Slew step saturates here: no gap is ever larger than full scale.
  localparam logic [16:0] STEP_SAT   = 17'h10000;

  // Beat passed from the front end to the slew stage.
  typedef struct packed {
    logic [15:0] target;
    logic [16:0] step;
  } mid_beat_t;

endpackage

// ----- src/bpsd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boost pulse drive queue
// Small first-in first-out buffer with full and empty flags decoded from a registered fill count.
// ----------------------------------------------------------------------------
module bpsd_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/bpsd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boost pulse drive front end
// Holds configuration and boost state, works out the target and slew step.
// ----------------------------------------------------------------------------
module bpsd_front
  import bpsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        accept,
  input  logic [15:0] position,
  input  logic [7:0]  boost_request,
  input  logic [31:0] now_ms,
  output mid_beat_t   beat
);

  logic [15:0] min_drive_r, max_drive_r, boost_drive_r, slew_r;
  logic [7:0]  boosts_done_r, boosts_done_nxt;
  logic        pulse_active_r, pulse_active_nxt;
  logic [31:0] last_change_r, last_change_nxt;
  logic [31:0] last_update_r;

  logic [32:0] scaled_sum;
  logic [15:0] scaled, value, cap, target;
  logic [31:0] since_change, elapsed;
  logic [47:0] step_prod;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_drive_r   <= MIN_DRIVE_RST;
      max_drive_r   <= MAX_DRIVE_RST;
      boost_drive_r <= BOOST_DRIVE_RST;
      slew_r        <= SLEW_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_MIN_DRIVE:   min_drive_r   <= cfg_wdata;
        CFG_MAX_DRIVE:   max_drive_r   <= cfg_wdata;
        CFG_BOOST_DRIVE: boost_drive_r <= cfg_wdata;
        CFG_SLEW_PER_MS: slew_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Scaled throttle position, rounded, floored at the minimum drive.
  assign scaled_sum = {1'b0, 32'(position) * 32'(max_drive_r)} + ROUND_HALF;
  assign scaled     = scaled_sum[31:16];
  assign value      = (scaled > min_drive_r) ? scaled : min_drive_r;
  assign cap        = (max_drive_r > CAP_MARGIN) ? max_drive_r - CAP_MARGIN : '0;
  assign since_change = now_ms - last_change_r;

  // Boost sequencing: pulse and gap phases of one second each.
  always_comb begin
    boosts_done_nxt  = boosts_done_r;
    pulse_active_nxt = pulse_active_r;
    last_change_nxt  = last_change_r;
    target           = value;
    if (boost_request < boosts_done_r) begin
      // A lowered request restarts the count and caps the drive.
      boosts_done_nxt  = '0;
      pulse_active_nxt = 1'b0;
      last_change_nxt  = now_ms;
      target           = (value < cap) ? value : cap;
    end else if (boost_request != boosts_done_r) begin
      if (since_change < PULSE_MS) begin
        target = pulse_active_r ? boost_drive_r : max_drive_r;
      end else begin
        if (pulse_active_r) begin
          target          = max_drive_r;
          boosts_done_nxt = boosts_done_r + 1'b1;
        end else begin
          target = boost_drive_r;
        end
        pulse_active_nxt = ~pulse_active_r;
        last_change_nxt  = now_ms;
      end
    end
  end

  // Largest drive change for the elapsed time, saturated at full scale.
  assign elapsed   = now_ms - last_update_r;
  assign step_prod = elapsed * {32'd0, slew_r};

  assign beat.target = target;
  assign beat.step   = (|step_prod[47:16]) ? STEP_SAT : {1'b0, step_prod[15:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boosts_done_r  <= '0;
      pulse_active_r <= 1'b0;
      last_change_r  <= '0;
      last_update_r  <= '0;
    end else if (accept) begin
      boosts_done_r  <= boosts_done_nxt;
      pulse_active_r <= pulse_active_nxt;
      last_change_r  <= last_change_nxt;
      last_update_r  <= now_ms;
    end
  end

endmodule

// ----- src/bpsd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boost pulse drive slew stage
// Moves the drive level toward the target by at most the slew step.
// ----------------------------------------------------------------------------
module bpsd_back
  import bpsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mid_beat_t   beat,
  input  logic        beat_valid,
  output logic        beat_take,
  input  logic        res_full,
  output logic        res_push,
  output logic [15:0] res_level
);

  logic [15:0] drive_r, drive_nxt;
  logic [16:0] gap, move;

  assign beat_take = beat_valid & ~res_full;
  assign res_push  = beat_take;

  // Slew-limited move toward the target.
  always_comb begin
    gap       = (beat.target > drive_r) ? {1'b0, beat.target - drive_r}
                                        : {1'b0, drive_r - beat.target};
    move      = (gap < beat.step) ? gap : beat.step;
    drive_nxt = (beat.target > drive_r) ? drive_r + move[15:0]
                                        : drive_r - move[15:0];
  end

  assign res_level = drive_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
    end else if (beat_take) begin
      drive_r <= drive_nxt;
    end
  end

endmodule

// ----- src/boost_pulse_slewed_pwm_drive.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boost pulse slewed PWM drive
// Throttle drive with timed boost pulses and a slew-limited PWM level.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+----------------------------------------
//  input    | in_push / in_full  | in_position, in_boost_request, in_now_ms
//  result   | out_pop / out_empty| out_pwm_out
//  config   | cfg_we             | cfg_idx, cfg_wdata
//
// One beat in per cycle while in_full is low; each result passes through the front queue
// and then the result queue, both registered, on its way from its input beat.
// Reset is synchronous, active low, and restores all registers but the queue storage to defaults.
// A stalled result side fills the result queue and then the front queue;
// in_full rises only after both have filled.
// ----------------------------------------------------------------------------
module boost_pulse_slewed_pwm_drive
  import bpsd_pkg::*;
#(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_position,
  input  logic [7:0]  in_boost_request,
  input  logic [31:0] in_now_ms,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [15:0] out_pwm_out
);

  logic      in_accept;
  mid_beat_t front_beat, mid_beat;
  logic      mid_empty, beat_take, res_full, res_push;
  logic [15:0] res_level;

  assign in_accept = in_push & ~in_full;

  // Front end: boost sequencing and slew step.
  bpsd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .accept        (in_accept),
    .position      (in_position),
    .boost_request (in_boost_request),
    .now_ms        (in_now_ms),
    .beat          (front_beat)
  );

  // Queue between front end and slew stage.
  bpsd_queue #(
    .WIDTH ($bits(mid_beat_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_beat),
    .full      (in_full),
    .pop       (beat_take),
    .pop_data  (mid_beat),
    .empty     (mid_empty)
  );

  // Slew stage.
  bpsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (mid_beat),
    .beat_valid (~mid_empty),
    .beat_take  (beat_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_level  (res_level)
  );

  // Result queue.
  bpsd_queue #(
    .WIDTH (16),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_level),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_pwm_out),
    .empty     (out_empty)
  );

endmodule
